// ----- rtl/mks_pkg.sv -----
package mks_pkg;

   localparam int STICK_W      = 11;
   localparam int SWITCH_W     = 2;
   localparam int DEADBAND_W   = 10;
   localparam int FULL_SPEED_W = 14;
   localparam int LIMIT_W      = 15;
   localparam int TARGET_W     = 16;
   localparam int MODE_W       = 2;
   localparam int HELD_W       = 16;
   localparam int MIX_W        = 18;
   localparam int MAG_W        = 17;
   localparam int MUL_B_W      = 15;
   localparam int PROD_W       = MAG_W + MUL_B_W;
   localparam int QUO_W        = 15;
   localparam int DIV_BITS     = 3;
   localparam int DIV_STEPS    = QUO_W / DIV_BITS;
   localparam int DIV_CNT_W    = $clog2(DIV_STEPS);
   localparam int AXES         = 3;
   localparam int WHEELS       = 4;
   localparam int IDX_W        = 2;
   localparam int CSR_ADDR_W   = 4;
   localparam int CSR_DATA_W   = 32;

   localparam logic [MAG_W-1:0] STICK_FULL_SCALE = MAG_W'(660);

   localparam logic [DEADBAND_W-1:0]   DEADBAND_RESET   = DEADBAND_W'(50);
   localparam logic [FULL_SPEED_W-1:0] FULL_SPEED_RESET = FULL_SPEED_W'(8000);
   localparam logic [LIMIT_W-1:0]      LIMIT_RESET      = LIMIT_W'(2000);

   localparam logic [MODE_W-1:0] MODE_DRIVE = MODE_W'(0);
   localparam logic [MODE_W-1:0] MODE_SLOW  = MODE_W'(1);
   localparam logic [MODE_W-1:0] MODE_ZERO  = MODE_W'(2);

   localparam logic [1:0] REG_DEADBAND   = 2'd0;
   localparam logic [1:0] REG_FULL_SPEED = 2'd1;
   localparam logic [1:0] REG_LIMIT      = 2'd2;

   localparam int AXIS_LAT  = 0;
   localparam int AXIS_FWD  = 1;
   localparam int AXIS_TURN = 2;

   typedef enum logic [3:0] {
      S_IDLE,
      S_AXIS_MUL,
      S_AXIS_DIV,
      S_MIX,
      S_MAX,
      S_CHECK,
      S_WHEEL_MUL,
      S_WHEEL_DIV,
      S_DONE
   } state_type;

   typedef struct packed {
      logic [DEADBAND_W-1:0]   deadband;
      logic [FULL_SPEED_W-1:0] full_speed;
      logic [LIMIT_W-1:0]      limit;
   } cfg_type;

   typedef struct packed {
      logic              start;
      logic [PROD_W-1:0] dividend;
      logic [MAG_W-1:0]  divisor;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [QUO_W-1:0] quotient;
   } div_rsp_type;

   function automatic logic [STICK_W-1:0] stick_mag(input logic signed [STICK_W-1:0] s);
      stick_mag = s[STICK_W-1] ? (~s + STICK_W'(1)) : s;
   endfunction

   function automatic logic [MAG_W-1:0] mix_mag(input logic signed [MIX_W-1:0] t);
      logic [MIX_W-1:0] u;
      u = t[MIX_W-1] ? (~t + MIX_W'(1)) : t;
      mix_mag = u[MAG_W-1:0];
   endfunction

endpackage

// ----- rtl/mks_if.sv -----
interface mks_req_if;
   import mks_pkg::*;
   logic                       valid;
   logic                       ready;
   logic signed [STICK_W-1:0]  lateral_stick;
   logic signed [STICK_W-1:0]  forward_stick;
   logic signed [STICK_W-1:0]  turn_stick;
   logic        [SWITCH_W-1:0] switch_position;

   modport source (output valid, lateral_stick, forward_stick, turn_stick, switch_position,
                   input ready);
   modport sink   (input valid, lateral_stick, forward_stick, turn_stick, switch_position,
                   output ready);
endinterface

interface mks_rsp_if;
   import mks_pkg::*;
   logic                       valid;
   logic                       ready;
   logic signed [TARGET_W-1:0] left_front_target;
   logic signed [TARGET_W-1:0] right_front_target;
   logic signed [TARGET_W-1:0] right_back_target;
   logic signed [TARGET_W-1:0] left_back_target;
   logic        [MODE_W-1:0]   drive_mode;

   modport source (output valid, left_front_target, right_front_target, right_back_target,
                   left_back_target, drive_mode, input ready);
   modport sink   (input valid, left_front_target, right_front_target, right_back_target,
                   left_back_target, drive_mode, output ready);
endinterface

// ----- rtl/mks_div.sv -----
module mks_div (
   input  logic                 clock,
   input  logic                 reset,
   input  mks_pkg::div_req_type div_req,
   output mks_pkg::div_rsp_type div_rsp
);
   import mks_pkg::*;

   logic [MAG_W-1:0]     rem_ff, rem_in;
   logic [QUO_W-1:0]     num_ff, num_in;
   logic [MAG_W-1:0]     divisor_ff, divisor_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [MAG_W:0]       r;
   logic [QUO_W-1:0]     n;
   logic                 ge;

   // radix-2 restoring steps, DIV_BITS per cycle; quotient shifts into num
   always_comb begin
      r  = {1'b0, rem_ff};
      n  = num_ff;
      ge = 1'b0;
      for (int k = 0; k < DIV_BITS; k++) begin
         r  = {r[MAG_W-1:0], n[QUO_W-1]};
         ge = (r >= {1'b0, divisor_ff});
         n  = {n[QUO_W-2:0], ge};
         if (ge) begin
            r = r - {1'b0, divisor_ff};
         end
      end
   end

   always_comb begin
      rem_in     = rem_ff;
      num_in     = num_ff;
      divisor_in = divisor_ff;
      cnt_in     = cnt_ff;
      busy_in    = busy_ff;
      done_in    = 1'b0;
      if (div_req.start) begin
         rem_in     = div_req.dividend[PROD_W-1:QUO_W];
         num_in     = div_req.dividend[QUO_W-1:0];
         divisor_in = div_req.divisor;
         cnt_in     = '0;
         busy_in    = 1'b1;
      end else if (busy_ff) begin
         rem_in = r[MAG_W-1:0];
         num_in = n;
         cnt_in = cnt_ff + DIV_CNT_W'(1);
         if (cnt_ff == DIV_CNT_W'(DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff     <= rem_in;
      num_ff     <= num_in;
      divisor_ff <= divisor_in;
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = num_ff;

endmodule

// ----- rtl/mks_csr.sv -----
module mks_csr (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [mks_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [mks_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [mks_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                           csr_pready,
   output mks_pkg::cfg_type               cfg
);
   import mks_pkg::*;

   cfg_type    cfg_ff, cfg_in;
   logic [1:0] reg_idx;
   logic       wr;

   assign reg_idx    = csr_paddr[3:2];
   assign csr_pready = 1'b1;
   assign wr         = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      cfg_in     = cfg_ff;
      csr_prdata = '0;
      case (reg_idx)
         REG_DEADBAND: begin
            csr_prdata = CSR_DATA_W'(cfg_ff.deadband);
            if (wr) begin
               cfg_in.deadband = csr_pwdata[DEADBAND_W-1:0];
            end
         end
         REG_FULL_SPEED: begin
            csr_prdata = CSR_DATA_W'(cfg_ff.full_speed);
            if (wr) begin
               cfg_in.full_speed = csr_pwdata[FULL_SPEED_W-1:0];
            end
         end
         REG_LIMIT: begin
            csr_prdata = CSR_DATA_W'(cfg_ff.limit);
            if (wr) begin
               cfg_in.limit = csr_pwdata[LIMIT_W-1:0];
            end
         end
         default: begin
            csr_prdata = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.deadband   <= DEADBAND_RESET;
         cfg_ff.full_speed <= FULL_SPEED_RESET;
         cfg_ff.limit      <= LIMIT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ----- rtl/mecanum_stick_to_wheel_speeds_unit.sv -----
// Mecanum stick-to-wheel speed unit.
// req carries one remote frame per beat (three signed sticks and the mode
// switch); rsp carries four limited wheel targets and the drive mode.
// Registers (deadband, full-scale axis speed, wheel limit) sit on the csr_
// APB port at byte addresses 0, 4 and 8; pready is tied high.
// One frame is worked at a time by a shared 17x15 multiplier feeding a
// divider that retires 3 quotient bits per cycle. A frame in which no axis is
// reloaded and no scaling is needed skips every divide; a drive frame with
// scaling runs 3 axis divides and 4 wheel divides. The next frame is taken
// in the cycle after the previous one leaves the datapath.
// The result waits in an output register; if rsp is stalled, the next frame
// is still accepted and runs until its result needs that register.
// Synchronous reset clears the held axis speeds to zero and loads the
// register defaults (50, 8000, 2000).
module mecanum_stick_to_wheel_speeds_unit (
   input  logic                           clock,
   input  logic                           reset,
   mks_req_if.sink                        req,
   mks_rsp_if.source                      rsp,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [mks_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [mks_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [mks_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                           csr_pready
);
   import mks_pkg::*;

   cfg_type     cfg;
   div_req_type div_req;
   div_rsp_type div_rsp;

   state_type                  state_ff, state_in;
   logic [IDX_W-1:0]           idx_ff, idx_in;
   logic signed [STICK_W-1:0]  stick_ff [AXES];
   logic signed [STICK_W-1:0]  stick_in [AXES];
   logic signed [HELD_W-1:0]   held_ff [AXES];
   logic signed [HELD_W-1:0]   held_in [AXES];
   logic signed [MIX_W-1:0]    t_ff [WHEELS];
   logic signed [MIX_W-1:0]    t_in [WHEELS];
   logic [MAG_W-1:0]           max_ff, max_in;
   logic [MODE_W-1:0]          mode_ff, mode_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic signed [TARGET_W-1:0] out_ff [WHEELS];
   logic signed [TARGET_W-1:0] out_in [WHEELS];
   logic [MODE_W-1:0]          out_mode_ff, out_mode_in;

   logic [MAG_W-1:0]           mul_a;
   logic [MUL_B_W-1:0]         mul_b;
   logic [PROD_W-1:0]          product;
   logic signed [MIX_W-1:0]    fx, lx, rx;
   logic [MAG_W-1:0]           m0, m1, m2, m3, m01, m23;
   logic signed [HELD_W-1:0]   q_held;
   logic signed [MIX_W-1:0]    q_mix;
   logic                       in_dead;
   logic                       out_free;

   mks_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   mks_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign req.ready = (state_ff == S_IDLE);
   assign out_free  = !rsp_valid_ff || rsp.ready;

   assign in_dead = (stick_mag(req.lateral_stick) <= {1'b0, cfg.deadband})
                 && (stick_mag(req.forward_stick) <= {1'b0, cfg.deadband})
                 && (stick_mag(req.turn_stick)    <= {1'b0, cfg.deadband});

   // shared multiplier: stick magnitude x full speed, or |target| x limit
   always_comb begin
      if (state_ff == S_WHEEL_MUL) begin
         mul_a = mix_mag(t_ff[idx_ff]);
         mul_b = cfg.limit;
      end else begin
         mul_a = MAG_W'(stick_mag(stick_ff[idx_ff]));
         mul_b = MUL_B_W'(cfg.full_speed);
      end
   end
   assign product = mul_a * mul_b;

   assign div_req.start    = (state_ff == S_AXIS_MUL) || (state_ff == S_WHEEL_MUL);
   assign div_req.dividend = product;
   assign div_req.divisor  = (state_ff == S_WHEEL_MUL) ? max_ff : STICK_FULL_SCALE;

   assign q_held = stick_ff[idx_ff][STICK_W-1] ? -HELD_W'(div_rsp.quotient)
                                               : HELD_W'(div_rsp.quotient);
   assign q_mix  = t_ff[idx_ff][MIX_W-1] ? -MIX_W'(div_rsp.quotient)
                                         : MIX_W'(div_rsp.quotient);

   assign fx = MIX_W'(held_ff[AXIS_FWD]);
   assign lx = MIX_W'(held_ff[AXIS_LAT]);
   assign rx = MIX_W'(held_ff[AXIS_TURN]);

   assign m0  = mix_mag(t_ff[0]);
   assign m1  = mix_mag(t_ff[1]);
   assign m2  = mix_mag(t_ff[2]);
   assign m3  = mix_mag(t_ff[3]);
   assign m01 = (m0 > m1) ? m0 : m1;
   assign m23 = (m2 > m3) ? m2 : m3;

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      stick_in     = stick_ff;
      held_in      = held_ff;
      t_in         = t_ff;
      max_in       = max_ff;
      mode_in      = mode_ff;
      out_in       = out_ff;
      out_mode_in  = out_mode_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      case (state_ff)
         S_IDLE: begin
            if (req.valid) begin
               stick_in[AXIS_LAT]  = req.lateral_stick;
               stick_in[AXIS_FWD]  = req.forward_stick;
               stick_in[AXIS_TURN] = req.turn_stick;
               idx_in              = '0;
               if (!req.switch_position[0]) begin
                  mode_in  = MODE_ZERO;
                  state_in = S_MIX;
               end else if (in_dead) begin
                  mode_in  = MODE_SLOW;
                  state_in = S_MIX;
               end else begin
                  mode_in  = MODE_DRIVE;
                  state_in = S_AXIS_MUL;
               end
            end
         end
         S_AXIS_MUL: begin
            state_in = S_AXIS_DIV;
         end
         S_AXIS_DIV: begin
            if (div_rsp.done) begin
               held_in[idx_ff] = q_held;
               if (idx_ff == IDX_W'(AXES - 1)) begin
                  state_in = S_MIX;
               end else begin
                  idx_in   = idx_ff + IDX_W'(1);
                  state_in = S_AXIS_MUL;
               end
            end
         end
         S_MIX: begin
            t_in[0]  = fx + lx + rx;
            t_in[1]  = lx - fx + rx;
            t_in[2]  = rx - fx - lx;
            t_in[3]  = fx - lx + rx;
            state_in = S_MAX;
         end
         S_MAX: begin
            max_in   = (m01 > m23) ? m01 : m23;
            state_in = S_CHECK;
         end
         S_CHECK: begin
            idx_in = '0;
            if (max_ff > MAG_W'(cfg.limit)) begin
               state_in = S_WHEEL_MUL;
            end else begin
               state_in = S_DONE;
            end
         end
         S_WHEEL_MUL: begin
            state_in = S_WHEEL_DIV;
         end
         S_WHEEL_DIV: begin
            if (div_rsp.done) begin
               t_in[idx_ff] = q_mix;
               if (idx_ff == IDX_W'(WHEELS - 1)) begin
                  state_in = S_DONE;
               end else begin
                  idx_in   = idx_ff + IDX_W'(1);
                  state_in = S_WHEEL_MUL;
               end
            end
         end
         S_DONE: begin
            if (out_free) begin
               for (int w = 0; w < WHEELS; w++) begin
                  out_in[w] = t_ff[w][TARGET_W-1:0];
               end
               out_mode_in  = mode_ff;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         for (int a = 0; a < AXES; a++) begin
            held_ff[a] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
         held_ff      <= held_in;
      end
   end

   always_ff @(posedge clock) begin
      stick_ff    <= stick_in;
      t_ff        <= t_in;
      max_ff      <= max_in;
      mode_ff     <= mode_in;
      out_ff      <= out_in;
      out_mode_ff <= out_mode_in;
   end

   assign rsp.valid              = rsp_valid_ff;
   assign rsp.left_front_target  = out_ff[0];
   assign rsp.right_front_target = out_ff[1];
   assign rsp.right_back_target  = out_ff[2];
   assign rsp.left_back_target   = out_ff[3];
   assign rsp.drive_mode         = out_mode_ff;

endmodule
